// ===== design/tocal_pkg.sv =====
package tocal_pkg;

	localparam int TABLE_DEPTH_DEF = 4096;
	localparam int PROBE_LIMIT_DEF = 8;
	localparam int ATLAS_BYTES_DEF = 16 * 1024 * 1024;

	localparam int KEY_W      = 32;
	localparam int SIZE_W     = 25;
	localparam int OFF_W      = 24;
	localparam int HASH_SHIFT = 4;
	localparam int HASH_BITS  = KEY_W - HASH_SHIFT;
	localparam int ALIGN_MASK = 15;
	localparam int CMP_W      = 30;  // holds any atlas size in range

	localparam int IN_DATA_W  = 64;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 3;

	localparam int ALU_W_DEF  = 26;

	// request kinds on s_axis_tuser
	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_RESET  = 1'b1;

	// shared adder operations
	typedef logic [1:0] alu_op_t;
	localparam alu_op_t ALU_ADD = 2'd0;
	localparam alu_op_t ALU_SUB = 2'd1;
	localparam alu_op_t ALU_INC = 2'd2;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
		logic [OFF_W-1:0]  offset;
	} entry_t;

endpackage

// ===== design/tocal_alu.sv =====
module tocal_alu #(
	parameter int WIDTH = tocal_pkg::ALU_W_DEF
) (
	input  tocal_pkg::alu_op_t op,
	input  logic [WIDTH-1:0]   a,
	input  logic [WIDTH-1:0]   b,
	output logic [WIDTH-1:0]   res,
	output logic               carry
);
	import tocal_pkg::*;

	logic [WIDTH-1:0] b_x;
	logic             cin;

	always_comb begin
		b_x = b;
		cin = 1'b0;
		unique case (op)
			ALU_ADD: begin
				b_x = b;
				cin = 1'b0;
			end
			ALU_SUB: begin
				b_x = ~b;
				cin = 1'b1;
			end
			ALU_INC: begin
				b_x = '0;
				cin = 1'b1;
			end
			default: begin
				b_x = b;
				cin = 1'b0;
			end
		endcase
	end

	// carry out on subtract means a >= b
	assign {carry, res} = {1'b0, a} + {1'b0, b_x} + (WIDTH + 1)'(cin);

endmodule

// ===== design/tocal_table.sv =====
module tocal_table #(
	parameter int DEPTH  = tocal_pkg::TABLE_DEPTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  tocal_pkg::entry_t wr_entry,
	input  logic [ADDR_W-1:0] rd_addr,
	output tocal_pkg::entry_t rd_entry
);
	import tocal_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		rd_entry <= mem[rd_addr];
	end

endmodule

// ===== design/texture_offset_cache_allocator_core.sv =====
// Offset cache with bump allocator for an atlas memory.
// Input channel s_axis: one request per handshake. s_axis_tuser selects a
// lookup/allocate (0) or a table reset (1); s_axis_tdata carries the source
// key and the byte size. Output channel m_axis: exactly one result per
// request, the atlas offset on m_axis_tdata and the hit, wrapped and stored
// flags on m_axis_tuser.
// Requests are handled one at a time; s_axis_tready is high only while the
// sequencer is idle. A lookup probes the table memory one slot per cycle
// through a registered read, up to PROBE_LIMIT slots (8 by default); an
// insert adds a table write. With a depth that is not a power of two the
// hash remainder is worked out bit-serially over the 28 hashed key bits on
// the shared adder. A table reset request, and an atlas overflow, run a
// clearing pass over the table memory, one entry per cycle. After arst_n
// the same clearing pass runs before the first request is taken. A
// finished result sits in the output register; the next request is
// accepted meanwhile, and its result waits until the receiver has taken
// the previous one.
module texture_offset_cache_allocator_core #(
	parameter int TABLE_DEPTH = tocal_pkg::TABLE_DEPTH_DEF,
	parameter int PROBE_LIMIT = tocal_pkg::PROBE_LIMIT_DEF,
	parameter int ATLAS_BYTES = tocal_pkg::ATLAS_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [31:0] source_key, [56:32] byte_size, [63:57] zero
	input  logic [tocal_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [0] req_type
	input  logic [tocal_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [23:0] atlas_offset
	output logic [tocal_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [0] hit, [1] wrapped, [2] stored
	output logic [tocal_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import tocal_pkg::*;

	localparam int  IW        = $clog2(TABLE_DEPTH);
	localparam int  PW        = $clog2(ATLAS_BYTES + 1);
	localparam int  AW        = (PW + 1 > IW + 2) ? PW + 1 : IW + 2;
	localparam int  CW        = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
	localparam bit  HASH_POW2 = (TABLE_DEPTH == (1 << IW));

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLEAR = 4'd1;
	localparam logic [3:0] S_HASH  = 4'd2;
	localparam logic [3:0] S_PROBE = 4'd3;
	localparam logic [3:0] S_ALIGN = 4'd4;
	localparam logic [3:0] S_FIT   = 4'd5;
	localparam logic [3:0] S_WRITE = 4'd6;
	localparam logic [3:0] S_DONE  = 4'd7;

	// where the clearing pass returns to
	localparam logic [1:0] RET_IDLE  = 2'd0;
	localparam logic [1:0] RET_DONE  = 2'd1;
	localparam logic [1:0] RET_WRITE = 2'd2;

	logic [3:0]        state_q;
	logic [1:0]        clr_ret_q;
	logic [IW-1:0]     slot_q, slot_d, home_q, wr_slot_q, rem_q;
	logic [CW-1:0]     probe_q;
	logic [4:0]        hbit_q;
	logic              empty_q;
	logic [PW-1:0]     fp_q;
	logic [AW-1:0]     aligned_q;
	logic [KEY_W-1:0]  key_q;
	logic [SIZE_W-1:0] size_q;
	logic [OFF_W-1:0]  res_off_q;
	logic              res_hit_q, res_wrap_q, res_stored_q;

	logic              in_acc, in_bad;
	logic [KEY_W-1:0]  in_key;
	logic [SIZE_W-1:0] in_size;

	alu_op_t           alu_op;
	logic [AW-1:0]     alu_a, alu_b, alu_res;
	logic              alu_c;
	logic [IW-1:0]     slot_inc, hash_next;
	logic [IW:0]       hash_shift;
	logic [4:0]        key_bit_idx;
	logic              match, last_probe, overflow, out_free;

	logic              tbl_we;
	entry_t            tbl_wdata, rd_entry;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_key        = s_axis_tdata[KEY_W-1:0];
	assign in_size       = s_axis_tdata[KEY_W +: SIZE_W];
	assign in_bad        = (in_key == '0) || (in_size == '0)
	                       || (CMP_W'(in_size) > CMP_W'(ATLAS_BYTES));

	assign key_bit_idx = hbit_q + 5'(HASH_SHIFT);
	assign hash_shift  = {rem_q, key_q[key_bit_idx]};

	// shared adder: slot stepping, hash remainder, alignment, fit check
	always_comb begin
		alu_op = ALU_INC;
		alu_a  = AW'(slot_q);
		alu_b  = '0;
		unique case (state_q)
			S_HASH: begin
				alu_op = ALU_SUB;
				alu_a  = AW'(hash_shift);
				alu_b  = AW'(TABLE_DEPTH);
			end
			S_ALIGN: begin
				alu_op = ALU_ADD;
				alu_a  = AW'(fp_q);
				alu_b  = AW'(ALIGN_MASK);
			end
			S_FIT: begin
				alu_op = ALU_ADD;
				alu_a  = aligned_q;
				alu_b  = AW'(size_q);
			end
			default: begin
				alu_op = ALU_INC;
				alu_a  = AW'(slot_q);
				alu_b  = '0;
			end
		endcase
	end

	tocal_alu #(
		.WIDTH(AW)
	) u_alu (
		.op   (alu_op),
		.a    (alu_a),
		.b    (alu_b),
		.res  (alu_res),
		.carry(alu_c)
	);

	assign slot_inc   = (alu_res == AW'(TABLE_DEPTH)) ? '0 : alu_res[IW-1:0];
	assign hash_next  = alu_c ? alu_res[IW-1:0] : hash_shift[IW-1:0];
	assign match      = (rd_entry.key == key_q) && (rd_entry.size == size_q);
	assign last_probe = (probe_q == CW'(PROBE_LIMIT - 1));
	assign overflow   = (CMP_W'(alu_res) > CMP_W'(ATLAS_BYTES));
	assign out_free   = !m_axis_tvalid || m_axis_tready;

	// next slot also drives the table read address
	always_comb begin
		slot_d = slot_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (s_axis_tuser[0] == REQ_RESET) begin
						slot_d = '0;
					end else if (HASH_POW2) begin
						slot_d = in_key[HASH_SHIFT +: IW];
					end
				end
			end
			S_CLEAR: slot_d = slot_inc;
			S_HASH: begin
				if (hbit_q == '0) begin
					slot_d = hash_next;
				end
			end
			S_PROBE: begin
				if (rd_entry.valid && !match && !last_probe) begin
					slot_d = slot_inc;
				end
			end
			S_FIT: begin
				if (overflow) begin
					slot_d = '0;
				end
			end
			default: slot_d = slot_q;
		endcase
	end

	always_comb begin
		tbl_we    = 1'b0;
		tbl_wdata = '0;
		if (state_q == S_CLEAR) begin
			tbl_we = 1'b1;
		end else if (state_q == S_WRITE) begin
			tbl_we    = 1'b1;
			tbl_wdata = '{valid: 1'b1, key: key_q, size: size_q, offset: res_off_q};
		end
	end

	tocal_table #(
		.DEPTH (TABLE_DEPTH),
		.ADDR_W(IW)
	) u_table (
		.clk     (clk),
		.wr_en   (tbl_we),
		.wr_addr ((state_q == S_CLEAR) ? slot_q : wr_slot_q),
		.wr_entry(tbl_wdata),
		.rd_addr (slot_d),
		.rd_entry(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_ret_q <= RET_IDLE;
			slot_q    <= '0;
			fp_q      <= '0;
		end else begin
			slot_q <= slot_d;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (s_axis_tuser[0] == REQ_RESET) begin
							fp_q      <= '0;
							clr_ret_q <= RET_DONE;
							state_q   <= S_CLEAR;
						end else if (in_bad) begin
							state_q <= S_DONE;
						end else if (HASH_POW2) begin
							state_q <= S_PROBE;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_CLEAR: begin
					if (slot_q == IW'(TABLE_DEPTH - 1)) begin
						unique case (clr_ret_q)
							RET_DONE:  state_q <= S_DONE;
							RET_WRITE: state_q <= S_WRITE;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_HASH: begin
					if (hbit_q == '0) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (!rd_entry.valid || !match && last_probe) begin
						state_q <= S_ALIGN;
					end else if (match) begin
						state_q <= S_DONE;
					end
				end
				S_ALIGN: state_q <= S_FIT;
				S_FIT: begin
					if (overflow) begin
						fp_q      <= PW'(size_q);
						clr_ret_q <= RET_WRITE;
						state_q   <= S_CLEAR;
					end else begin
						fp_q    <= alu_res[PW-1:0];
						state_q <= empty_q ? S_WRITE : S_DONE;
					end
				end
				S_WRITE: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request data path, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				key_q        <= in_key;
				size_q       <= in_size;
				res_off_q    <= '0;
				res_hit_q    <= 1'b0;
				res_wrap_q   <= 1'b0;
				res_stored_q <= 1'b0;
				probe_q      <= '0;
				empty_q      <= 1'b0;
				rem_q        <= '0;
				hbit_q       <= 5'(HASH_BITS - 1);
				home_q       <= slot_d;
			end
			S_HASH: begin
				rem_q  <= hash_next;
				hbit_q <= hbit_q - 5'd1;
				home_q <= hash_next;
			end
			S_PROBE: begin
				probe_q <= probe_q + CW'(1);
				if (!rd_entry.valid) begin
					wr_slot_q <= slot_q;
					empty_q   <= 1'b1;
				end else if (match) begin
					res_off_q <= rd_entry.offset;
					res_hit_q <= 1'b1;
				end
			end
			S_ALIGN: begin
				aligned_q <= alu_res & ~AW'(ALIGN_MASK);
			end
			S_FIT: begin
				if (overflow) begin
					aligned_q  <= '0;
					res_off_q  <= '0;
					res_wrap_q <= 1'b1;
					wr_slot_q  <= home_q;
				end else begin
					res_off_q <= OFF_W'(aligned_q);
				end
			end
			S_WRITE: begin
				res_stored_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			m_axis_tdata <= res_off_q;
			m_axis_tuser <= {res_stored_q, res_wrap_q, res_hit_q};
		end
	end

`ifndef SYNTHESIS
	a_fp_in_atlas: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(fp_q) <= CMP_W'(ATLAS_BYTES))
		else $error("fill pointer past atlas end");

	a_hit_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] == 2'b00)
		else $error("hit result also flags wrap or store");

	a_wrap_stores: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[2] && m_axis_tdata == '0)
		else $error("wrap did not store at home slot with offset zero");

	a_offset_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[3:0] == 4'd0)
		else $error("atlas offset not 16 byte aligned");

	a_probe_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROBE && $past(state_q == S_PROBE) |-> probe_q != '0)
		else $error("probe counter wrapped within one lookup");
`endif

endmodule

// ===== bench/atlas_offset_checker.sv =====
`timescale 1ns / 100ps

module atlas_offset_checker
	import tocal_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic [OUT_USER_W-1:0] m_axis_tuser,
	output int                    fail_count,
	output int                    results_owed
);

	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic             hit;
		logic             wrapped;
		logic             stored;
	} atlas_result_t;

	// shadow of the offset table and the bump pointer
	bit   [TABLE_DEPTH_DEF-1:0] slot_valid;
	logic [KEY_W-1:0]           slot_key  [TABLE_DEPTH_DEF];
	logic [SIZE_W-1:0]          slot_size [TABLE_DEPTH_DEF];
	logic [OFF_W-1:0]           slot_off  [TABLE_DEPTH_DEF];
	logic [SIZE_W-1:0]          fill_ptr;

	atlas_result_t owed_q[$];
	atlas_result_t want;

	initial fail_count = 0;

	function automatic atlas_result_t lookup_or_allocate(input logic req_kind,
			input logic [KEY_W-1:0] key, input logic [SIZE_W-1:0] bytes);
		atlas_result_t    res;
		int unsigned      home;
		int unsigned      slot;
		int               p;
		logic [CMP_W-1:0] aligned;
		bit               done;
		res = '0;
		if (req_kind == REQ_RESET) begin
			slot_valid = '0;
			fill_ptr   = '0;
			return res;
		end
		if (key == '0 || bytes == '0 || bytes > ATLAS_BYTES_DEF)
			return res;
		home = (key >> HASH_SHIFT) % TABLE_DEPTH_DEF;
		// probe until the first empty slot, a match or the probe limit
		for (p = 0; p < PROBE_LIMIT_DEF; p++) begin
			slot = (home + p) % TABLE_DEPTH_DEF;
			if (!slot_valid[slot])
				break;
			if (slot_key[slot] == key && slot_size[slot] == bytes) begin
				res.offset = slot_off[slot];
				res.hit    = 1'b1;
				return res;
			end
		end
		aligned = (CMP_W'(fill_ptr) + CMP_W'(ALIGN_MASK)) & ~CMP_W'(ALIGN_MASK);
		if (aligned + CMP_W'(bytes) > CMP_W'(ATLAS_BYTES_DEF)) begin
			slot_valid  = '0;
			aligned     = '0;
			res.wrapped = 1'b1;
		end
		fill_ptr = SIZE_W'(aligned + CMP_W'(bytes));
		done = 1'b0;
		for (p = 0; p < PROBE_LIMIT_DEF && !done; p++) begin
			slot = (home + p) % TABLE_DEPTH_DEF;
			if (!slot_valid[slot]) begin
				slot_valid[slot] = 1'b1;
				slot_key[slot]   = key;
				slot_size[slot]  = bytes;
				slot_off[slot]   = aligned[OFF_W-1:0];
				res.stored       = 1'b1;
				done             = 1'b1;
			end
		end
		res.offset = aligned[OFF_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("%0t  %s: got %0h, expected %0h", $realtime, what, got, exp_val);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid = '0;
			fill_ptr   = '0;
			owed_q.delete();
			results_owed <= 0;
		end else begin
			// retire first: a result is always older than a request taken on the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_q.size() == 0) begin
					report_mismatch("result with no request outstanding",
						32'(m_axis_tdata), 32'(m_axis_tuser));
				end else begin
					want = owed_q.pop_front();
					if (m_axis_tdata[OFF_W-1:0] !== want.offset)
						report_mismatch("atlas_offset", 32'(m_axis_tdata[OFF_W-1:0]),
							32'(want.offset));
					if (m_axis_tuser[0] !== want.hit)
						report_mismatch("hit", 32'(m_axis_tuser[0]), 32'(want.hit));
					if (m_axis_tuser[1] !== want.wrapped)
						report_mismatch("wrapped", 32'(m_axis_tuser[1]), 32'(want.wrapped));
					if (m_axis_tuser[2] !== want.stored)
						report_mismatch("stored", 32'(m_axis_tuser[2]), 32'(want.stored));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				owed_q.push_back(lookup_or_allocate(s_axis_tuser[0],
					s_axis_tdata[KEY_W-1:0], s_axis_tdata[KEY_W +: SIZE_W]));
			results_owed <= owed_q.size();
		end
	end

endmodule

// ===== bench/tb_texture_offset_cache_allocator_core.sv =====
`timescale 1ns / 100ps

module tb_texture_offset_cache_allocator_core;
	import tocal_pkg::*;

	localparam int HOME_W      = $clog2(TABLE_DEPTH_DEF);
	localparam int BUSY_TARGET = 1430;  // random requests that do real work
	localparam int HOLD_EVERY  = 350;   // full drain of the pipe this often

	typedef struct {
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] bytes;
	} source_pair_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// [31:0] source_key, [56:32] byte_size, [63:57] zero
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	// [0] req_type
	logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [23:0] atlas_offset
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// [0] hit, [1] wrapped, [2] stored
	logic [OUT_USER_W-1:0] m_axis_tuser;

	int fail_count;
	int results_owed;

	// sender and receiver pacing
	bit sender_calm = 1'b0;
	int chunk_left  = 0;
	bit sink_calm   = 1'b0;
	int sink_mode_left = 0;
	int sink_hold   = 0;
	int sink_roll;

	// recent key/size pairs, replayed to get hits
	source_pair_t recent_pairs[$];

	logic              nxt_kind;
	logic [KEY_W-1:0]  nxt_key;
	logic [SIZE_W-1:0] nxt_bytes;
	bit                nxt_counts;
	int                busy_items;
	int                i;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	texture_offset_cache_allocator_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	atlas_offset_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.results_owed  (results_owed)
	);

	// Receiver: alternates calm stretches (always ready) with stretches of
	// random stalls, mostly short, now and then long.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_hold     <= 0;
		end else begin
			if (sink_mode_left == 0) begin
				sink_calm      = ($urandom_range(0, 3) == 0);
				sink_mode_left = $urandom_range(100, 600);
			end else begin
				sink_mode_left = sink_mode_left - 1;
			end
			if (sink_hold > 0) begin
				sink_hold <= sink_hold - 1;
			end else begin
				sink_roll = $urandom_range(0, 99);
				if (sink_calm || sink_roll < 65) begin
					m_axis_tready <= 1'b1;
					sink_hold     <= $urandom_range(0, 6);
				end else if (sink_roll < 95) begin
					m_axis_tready <= 1'b0;
					sink_hold     <= $urandom_range(0, 3);
				end else begin
					m_axis_tready <= 1'b0;
					sink_hold     <= $urandom_range(10, 60);
				end
			end
		end
	end

	// idle cycles after a request; none during calm stretches
	function automatic int pick_gap();
		int r;
		if (sender_calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	// Mostly small sizes so the atlas fills slowly; a few big ones force the
	// wrap and table clear, including the full atlas size.
	function automatic logic [SIZE_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 72)
			return SIZE_W'($urandom_range(1, 64));
		if (r < 86)
			return SIZE_W'($urandom_range(65, 4096));
		if (r < 97)
			return SIZE_W'($urandom_range(4097, 65536));
		if (r < 99)
			return SIZE_W'($urandom_range(1 << 20, ATLAS_BYTES_DEF - 1));
		return SIZE_W'(ATLAS_BYTES_DEF - $urandom_range(0, 1));
	endfunction

	// Drive one request and hold it until taken; then maybe idle.
	task automatic push_request(input logic req_kind, input logic [KEY_W-1:0] key,
			input logic [SIZE_W-1:0] bytes);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req_kind;
		s_axis_tdata  <= {{(IN_DATA_W - KEY_W - SIZE_W){1'b0}}, bytes, key};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending until every outstanding request has its result back. The
	// first edge lets the owed count catch a request taken on this edge.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
	endtask

	// Random request mix: table resets, invalid requests, replays of earlier
	// pairs (hits), same key with a new size, keys packed onto six homes
	// around the table end (full probe windows, probe wrap to slot 0),
	// and fresh keys.
	task automatic pick_request(output logic req_kind, output logic [KEY_W-1:0] key,
			output logic [SIZE_W-1:0] bytes, output bit counts);
		int           r;
		source_pair_t pair;
		r        = $urandom_range(0, 999);
		req_kind = REQ_LOOKUP;
		key      = $urandom;
		bytes    = pick_size();
		counts   = 1'b1;
		if (r < 15) begin
			req_kind = REQ_RESET;
		end else if (r < 45) begin
			counts = 1'b0;
			case ($urandom_range(0, 2))
				0: key = '0;
				1: bytes = '0;
				default: bytes = SIZE_W'($urandom_range(ATLAS_BYTES_DEF + 1, (1 << SIZE_W) - 1));
			endcase
		end else if (r < 400 && recent_pairs.size() > 0) begin
			pair = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
			key  = pair.key;
			// a slice of replays keeps the key but changes the size
			if (r < 350)
				bytes = pair.bytes;
		end else begin
			if (r < 650)
				key[HASH_SHIFT +: HOME_W] =
					HOME_W'((TABLE_DEPTH_DEF - 3 + $urandom_range(0, 5)) % TABLE_DEPTH_DEF);
			if (key != '0) begin
				pair.key   = key;
				pair.bytes = bytes;
				recent_pairs.push_back(pair);
				if (recent_pairs.size() > 48)
					recent_pairs.delete(0);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed requests ---
		push_request(REQ_LOOKUP, 32'h0000_0000, 25'd5);          // zero key
		push_request(REQ_LOOKUP, 32'h0000_0010, 25'd0);          // zero size
		push_request(REQ_LOOKUP, 32'hFFFF_FFFF, 25'h1FF_FFFF);   // oversize, all ones
		push_request(REQ_LOOKUP, 32'h0000_0020, SIZE_W'(ATLAS_BYTES_DEF + 1));
		push_request(REQ_LOOKUP, 32'h1234_5670, 25'd1);          // first allocation at 0
		push_request(REQ_LOOKUP, 32'h1234_5670, 25'd1);          // hit
		push_request(REQ_LOOKUP, 32'h1234_5670, 25'd2);          // same key, new size
		// whole atlas at once: does not fit behind the pointer, so it wraps
		push_request(REQ_LOOKUP, 32'hFFFF_FFFF, SIZE_W'(ATLAS_BYTES_DEF));
		// pointer now sits at the atlas end: even one byte wraps
		push_request(REQ_LOOKUP, 32'h0000_0010, 25'd1);
		push_request(REQ_RESET, $urandom, SIZE_W'($urandom));
		push_request(REQ_LOOKUP, 32'h1234_5670, 25'd1);          // table was cleared
		// nine keys on one home near the top: the probe wraps past the last
		// slot, and the ninth finds the window full and is not stored
		for (i = 0; i < 9; i++)
			push_request(REQ_LOOKUP, {16'(i + 1), 16'hFFE0}, SIZE_W'(i + 1));
		push_request(REQ_LOOKUP, {16'd8, 16'hFFE0}, 25'd8);      // hit on the last probe
		push_request(REQ_LOOKUP, {16'd9, 16'hFFE0}, 25'd9);      // still no room
		push_request(REQ_LOOKUP, 32'hFFFF_FFFF, SIZE_W'(ATLAS_BYTES_DEF - 1));

		// hold off until the pipe is empty
		drain_results();

		// --- random requests ---
		busy_items = 0;
		while (busy_items < BUSY_TARGET) begin
			if (chunk_left == 0) begin
				sender_calm = ($urandom_range(0, 3) == 0);
				chunk_left  = $urandom_range(20, 60);
			end
			chunk_left = chunk_left - 1;
			pick_request(nxt_kind, nxt_key, nxt_bytes, nxt_counts);
			push_request(nxt_kind, nxt_key, nxt_bytes);
			if (nxt_counts) begin
				busy_items++;
				if (busy_items % HOLD_EVERY == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run, clearing passes included.
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
